FILE: hw/rtl/first_fit_aligned_heap_allocator_unit_defines.svh
// assertion macros shared by the allocator modules
// needs a clock named clk and an active-low reset named rst_n in scope
`ifndef FIRST_FIT_ALIGNED_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_ALIGNED_HEAP_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define FFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ffa_pkg.sv
// shared types and constants of the first-fit heap allocator
// no dependencies
package ffa_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 12;
  localparam int SLOT_W       = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD      = 3'd1,
    ST_FULL     = 3'd2,
    ST_MISSING  = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } command_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_ACAND,
    S_ACHECK,
    S_FIND,
    S_COMMIT1,
    S_COMMIT2,
    S_FREAD,
    S_FCHECK,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    cand;
    logic    step;
    logic    scan;
    logic    commit1;
    logic    commit2;
    logic    free_commit;
    logic    set_res;
    status_t res_status;
    logic    out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_free;
    logic bad;
    logic full;
    logic live_zero;
    logic last;
    logic ovf;
    logic fit;
    logic fmatch;
    logic f_last;
    logic found;
  } dp_stat_t;

endpackage

FILE: hw/rtl/ffa_in_if.sv
// request channel of the allocator: valid/ready plus request fields
// no dependencies
interface ffa_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] request_size;
  logic [31:0] alignment;
  logic [31:0] free_address;

  modport source (output valid, command, request_size, alignment, free_address,
                  input ready);
  modport sink   (input valid, command, request_size, alignment, free_address,
                  output ready);
endinterface

FILE: hw/rtl/ffa_out_if.sv
// result channel of the allocator: valid/ready plus result fields
// no dependencies
interface ffa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_address;
  logic [2:0]  status;

  modport source (output valid, data_address, status, input ready);
  modport sink   (input valid, data_address, status, output ready);
endinterface

FILE: hw/rtl/ffa_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module ffa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/ffa_ctrl.sv
// controller state machine of the allocator
// depends on ffa_pkg and the assertion macro header
`include "first_fit_aligned_heap_allocator_unit_defines.svh"
module ffa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_free,
  input  ffa_pkg::dp_stat_t stat,
  output ffa_pkg::ctrl_cmd_t cmd
);
  import ffa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.res_status = ST_OK;
    in_ready       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        priority if (stat.is_free) begin
          if (stat.live_zero) begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_MISSING;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_FREAD;
          end
        end else if (stat.bad) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_BAD;
          state_nxt      = S_DONE;
        end else if (stat.full) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_ACAND;
        end
      end
      S_ACAND: begin
        cmd.cand  = 1'b1;
        cmd.scan  = 1'b1;
        state_nxt = S_ACHECK;
      end
      S_ACHECK: begin
        cmd.scan = 1'b1;
        priority if (stat.last) begin
          if (stat.ovf) begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_OVERFLOW;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_FIND;
          end
        end else if (stat.fit) begin
          state_nxt = S_FIND;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_ACAND;
        end
      end
      S_FIND: begin
        cmd.scan = 1'b1;
        if (stat.found) begin
          state_nxt = S_COMMIT1;
        end
      end
      S_COMMIT1: begin
        cmd.commit1 = 1'b1;
        state_nxt   = S_COMMIT2;
      end
      S_COMMIT2: begin
        cmd.commit2    = 1'b1;
        cmd.set_res    = 1'b1;
        cmd.res_status = ST_OK;
        state_nxt      = S_DONE;
      end
      S_FREAD: begin
        state_nxt = S_FCHECK;
      end
      S_FCHECK: begin
        priority if (stat.fmatch) begin
          cmd.free_commit = 1'b1;
          cmd.set_res     = 1'b1;
          cmd.res_status  = ST_OK;
          state_nxt       = S_DONE;
        end else if (stat.f_last) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_MISSING;
          state_nxt      = S_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_FREAD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `FFA_ASSERT_NEXT(a_commit_pair, state_r == S_COMMIT1, state_r == S_COMMIT2, "commit split")
  `FFA_ASSERT_NEXT(a_load_start, cmd.load, state_r == S_START, "load without start")
  `FFA_ASSERT_NOW(a_outload_done, cmd.out_load, state_r == S_DONE && out_free, "stray out load")
endmodule

FILE: hw/rtl/ffa_dp.sv
// datapath of the allocator: request latch, walk registers, block tables
// depends on ffa_pkg, ffa_ram and the assertion macro header
`include "first_fit_aligned_heap_allocator_unit_defines.svh"
module ffa_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  ffa_pkg::ctrl_cmd_t cmd,
  output ffa_pkg::dp_stat_t  stat,
  input  logic [31:0]        heap_base,
  input  logic               in_command,
  input  logic [31:0]        in_request_size,
  input  logic [31:0]        in_alignment,
  input  logic [31:0]        in_free_address,
  output logic [31:0]        res_addr,
  output logic [2:0]         res_status
);
  import ffa_pkg::*;

  logic              req_cmd_r;
  logic [31:0]       req_size_r, req_al_r, req_faddr_r;
  logic [33:0]       end_r, data_r;
  logic [SLOT_W-1:0] node_r, cur_r, first_r, scan_r, slot_r;
  logic              at_head_r, fits_r, found_r;
  logic [CNT_W-1:0]  k_r, live_r;
  logic [MAX_BLOCKS-1:0] in_use_r;
  logic [31:0]       res_addr_r;
  status_t           res_status_r;

  logic [31:0]       rd_start, rd_len;
  logic [SLOT_W-1:0] rd_next, rd_prev;

  logic              s_we, l_we, n_we, p_we;
  logic [SLOT_W-1:0] s_wa, l_wa, n_wa, p_wa, n_wd, p_wd;
  logic [31:0]       s_wd, l_wd;

  logic [31:0]       mask;
  logic [33:0]       cand;
  logic [34:0]       data_plus;
  logic [CNT_W-1:0]  k_inc;
  logic              has_next;

  assign mask      = (req_al_r == 32'd0) ? 32'd0 : req_al_r - 32'd1;
  assign cand      = (end_r + 34'(HEADER_BYTES) + {2'b00, mask}) & ~{2'b00, mask};
  assign data_plus = {1'b0, data_r} + {3'b000, req_size_r};
  assign k_inc     = k_r + CNT_W'(1);
  assign has_next  = k_inc < live_r;

  always_comb begin
    stat.is_free   = (req_cmd_r == CMD_FREE);
    stat.bad       = (req_size_r == 32'd0) || ((req_al_r & (req_al_r - 32'd1)) != 32'd0);
    stat.full      = live_r >= CNT_W'(MAX_BLOCKS);
    stat.live_zero = (live_r == '0);
    stat.last      = (k_r == live_r);
    stat.ovf       = data_plus > 35'h1_0000_0000;
    stat.fit       = data_plus <= {3'b000, rd_start};
    stat.fmatch    = ({1'b0, rd_start} + 33'(HEADER_BYTES)) == {1'b0, req_faddr_r};
    stat.f_last    = (k_inc == live_r);
    stat.found     = found_r;
  end

  // table writes
  always_comb begin
    s_we = 1'b0; s_wa = slot_r; s_wd = data_r[31:0] - 32'(HEADER_BYTES);
    l_we = 1'b0; l_wa = slot_r; l_wd = req_size_r;
    n_we = 1'b0; n_wa = slot_r; n_wd = fits_r ? node_r : '0;
    p_we = 1'b0; p_wa = slot_r; p_wd = at_head_r ? '0 : cur_r;
    if (cmd.commit1) begin
      s_we = 1'b1;
      l_we = 1'b1;
      n_we = 1'b1;
      p_we = 1'b1;
    end
    if (cmd.commit2) begin
      p_we = fits_r;
      p_wa = node_r;
      p_wd = slot_r;
      n_we = !at_head_r;
      n_wa = cur_r;
      n_wd = slot_r;
    end
    if (cmd.free_commit) begin
      n_we = (k_r != '0);
      n_wa = rd_prev;
      n_wd = rd_next;
      p_we = has_next;
      p_wa = rd_next;
      p_wd = (k_r == '0) ? '0 : rd_prev;
    end
  end

  ffa_ram #(.WIDTH(32), .DEPTH(MAX_BLOCKS)) u_start (
    .clk, .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(node_r), .rdata(rd_start));
  ffa_ram #(.WIDTH(32), .DEPTH(MAX_BLOCKS)) u_len (
    .clk, .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(node_r), .rdata(rd_len));
  ffa_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_BLOCKS)) u_next (
    .clk, .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(node_r), .rdata(rd_next));
  ffa_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_BLOCKS)) u_prev (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(node_r), .rdata(rd_prev));

  // request and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_cmd_r   <= in_command;
      req_size_r  <= in_request_size;
      req_al_r    <= in_alignment;
      req_faddr_r <= in_free_address;
      end_r       <= {2'b00, heap_base} + 34'(HEADER_BYTES);
      node_r      <= first_r;
      cur_r       <= '0;
      at_head_r   <= 1'b1;
      k_r         <= '0;
      scan_r      <= '0;
      fits_r      <= 1'b0;
    end
    if (cmd.cand) begin
      data_r <= cand;
    end
    if (cmd.scan && stat.last == 1'b0 && stat.fit && !cmd.cand) begin
      fits_r <= 1'b1;
    end
    if (cmd.step) begin
      end_r     <= {2'b00, rd_start} + 34'(HEADER_BYTES) + {2'b00, rd_len};
      cur_r     <= node_r;
      at_head_r <= 1'b0;
      node_r    <= rd_next;
      k_r       <= k_inc;
    end
    if (cmd.scan && !found_r && in_use_r[scan_r]) begin
      scan_r <= scan_r + SLOT_W'(1);
    end
    if (cmd.scan && !found_r && !in_use_r[scan_r]) begin
      slot_r <= scan_r;
    end
    if (cmd.set_res) begin
      res_addr_r   <= (cmd.res_status == ST_OK && !req_cmd_r) ? data_r[31:0] : 32'd0;
      res_status_r <= cmd.res_status;
    end
  end

  // control state of the tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      first_r  <= '0;
      live_r   <= '0;
      found_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        found_r <= 1'b0;
      end else if (cmd.scan && !in_use_r[scan_r]) begin
        found_r <= 1'b1;
      end
      if (cmd.commit1) begin
        in_use_r[slot_r] <= 1'b1;
        live_r           <= live_r + CNT_W'(1);
        if (at_head_r) begin
          first_r <= slot_r;
        end
      end
      if (cmd.free_commit) begin
        in_use_r[node_r] <= 1'b0;
        live_r           <= live_r - CNT_W'(1);
        if (k_r == '0) begin
          first_r <= has_next ? rd_next : '0;
        end
      end
    end
  end

  assign res_addr   = res_addr_r;
  assign res_status = res_status_r;

  `FFA_ASSERT_NOW(a_live_bound, 1'b1, live_r <= CNT_W'(MAX_BLOCKS), "live count too big")
  `FFA_ASSERT_NOW(a_live_bits, 1'b1, $countones(in_use_r) == 32'(live_r), "live count mismatch")
  `FFA_ASSERT_NOW(a_commit_slot_free, cmd.commit1, !in_use_r[slot_r], "slot taken twice")
endmodule

FILE: hw/rtl/first_fit_aligned_heap_allocator_unit.sv
// Address-ordered first-fit heap allocator with aligned placement. A request item
// either allocates (size, alignment) or frees a data address; each gives one result
// item (data address, status). Blocks live in four 64-entry tables walked as a
// linked list in address order, one table read per node. An allocate visits each node
// in two steps (candidate address, then compare against the registered table read),
// then may wait at the end of the walk for the free-slot search, which looks at one
// slot a cycle; a free walks the list until the block is found or the list ends, and
// a rejected request goes straight to the result. The block returns to idle before
// the next request is taken.
// The free-slot search runs alongside the walk. A new request is taken while the
// previous result still waits in the output register. heap_base is written through
// the APB port at byte address 0; the user must write it only while the block is
// idle, and the block itself does not enforce this.
module first_fit_aligned_heap_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  ffa_in_if.sink      in_ch,
  ffa_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ffa_pkg::*;

  ctrl_cmd_t   cmd;
  dp_stat_t    stat;
  logic [31:0] heap_base_r;
  logic [31:0] res_addr;
  logic [2:0]  res_status;
  logic        out_valid_r;
  logic [31:0] out_addr_r;
  logic [2:0]  out_status_r;
  logic        out_free;

  // config register, only heap_base at offset 0
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? heap_base_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= '0;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      heap_base_r <= pwdata;
    end
  end

  // output register decouples the walk from the consumer
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_addr_r   <= res_addr;
      out_status_r <= res_status;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.data_address = out_addr_r;
  assign out_ch.status       = out_status_r;

  ffa_ctrl u_ctrl (
    .clk,
    .rst_n,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_free,
    .stat,
    .cmd
  );

  ffa_dp u_dp (
    .clk,
    .rst_n,
    .cmd,
    .stat,
    .heap_base       (heap_base_r),
    .in_command      (in_ch.command),
    .in_request_size (in_ch.request_size),
    .in_alignment    (in_ch.alignment),
    .in_free_address (in_ch.free_address),
    .res_addr,
    .res_status
  );
endmodule

FILE: dv/tb.sv
// self-checking testbench of first_fit_aligned_heap_allocator_unit
// depends on ffa_pkg, ffa_in_if and ffa_out_if from the rtl
module tb;
  import ffa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;   // idle cycles before giving up
  localparam int SETTLE      = 160;    // longest walk over a full table, with margin
  localparam int CALM_TAIL   = 80;     // items at the end sent with no idling

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ffa_in_if  in_bus ();
  ffa_out_if out_bus ();

  first_fit_aligned_heap_allocator_unit u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // heap image: blocks in list order, header address and data length
  bit [31:0] heap_base_m;
  bit [31:0] blk_hdr[$];
  bit [31:0] blk_len[$];

  // results still owed by the block, oldest first
  bit [31:0] owed_addr[$];
  status_t   owed_status[$];

  bit failed;
  bit calm;          // no idling on either side
  int quiet_cycles;

  typedef struct {
    command_t  cmd;
    bit [31:0] size;
    bit [31:0] align;
    bit [31:0] faddr;
    bit        typed;    // expected result written in the row
    bit [31:0] exp_addr;
    status_t   exp_status;
  } stim_row_t;

  // free-running clock, 10 ns
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // first-fit placement and release over the heap image
  function automatic void place_or_release(input command_t cmd, input bit [31:0] size,
                                           input bit [31:0] align, input bit [31:0] faddr,
                                           output bit [31:0] addr, output status_t st);
    longint unsigned mask, tail, cand;
    int n;
    addr = '0;
    n = blk_hdr.size();
    if (cmd == CMD_FREE) begin
      st = ST_MISSING;
      for (int k = 0; k < n; k++) begin
        if (longint'(blk_hdr[k]) + HEADER_BYTES == longint'(faddr)) begin
          blk_hdr.delete(k);
          blk_len.delete(k);
          st = ST_OK;
          break;
        end
      end
      return;
    end
    if (size == 0 || (align & (align - 32'd1)) != 0) begin
      st = ST_BAD;
      return;
    end
    if (n >= MAX_BLOCKS) begin
      st = ST_FULL;
      return;
    end
    mask = (align == 0) ? 64'd0 : longint'(align) - 1;
    tail = longint'(heap_base_m) + HEADER_BYTES;
    for (int k = 0; k <= n; k++) begin
      cand = (tail + HEADER_BYTES + mask) & ~mask;
      if (k == n) begin
        // past the last block: always taken unless it runs off the top
        if (cand + size > 64'h1_0000_0000) begin
          st = ST_OVERFLOW;
          return;
        end
      end else if (cand + size > longint'(blk_hdr[k])) begin
        tail = longint'(blk_hdr[k]) + HEADER_BYTES + blk_len[k];
        continue;
      end
      blk_hdr.insert(k, 32'(cand - HEADER_BYTES));
      blk_len.insert(k, size);
      addr = 32'(cand);
      st = ST_OK;
      return;
    end
  endfunction

  // apb write: setup cycle, then access cycle
  task automatic write_heap_base(input bit [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= '0;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    heap_base_m = value;
  endtask

  // hold off until every owed result has come out, then let the walk finish
  task automatic wait_drained();
    while (owed_addr.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // one request item through the handshake; the prediction is made on acceptance
  task automatic send_item(input stim_row_t row);
    bit [31:0] p_addr;
    status_t   p_st;
    in_bus.valid        <= 1'b1;
    in_bus.command      <= row.cmd;
    in_bus.request_size <= row.size;
    in_bus.alignment    <= row.align;
    in_bus.free_address <= row.faddr;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    place_or_release(row.cmd, row.size, row.align, row.faddr, p_addr, p_st);
    if (row.typed && (p_addr != row.exp_addr || p_st != row.exp_status)) begin
      $display("%0t: table row disagrees: expected %h/%0d, predicted %h/%0d",
               $time, row.exp_addr, row.exp_status, p_addr, p_st);
      failed = 1'b1;
    end
    owed_addr.push_back(row.typed ? row.exp_addr : p_addr);
    owed_status.push_back(row.typed ? row.exp_status : p_st);
    // sender gap, landing on any phase of the walk
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  function automatic stim_row_t plain(input command_t cmd, input bit [31:0] size,
                                      input bit [31:0] align, input bit [31:0] faddr);
    stim_row_t r;
    r = '{cmd, size, align, faddr, 1'b0, '0, ST_OK};
    return r;
  endfunction

  // random request: mostly well-formed allocates and frees of live blocks
  function automatic stim_row_t random_item();
    int pick;
    bit [31:0] al, sz;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 64);
      case ($urandom_range(0, 5))
        0:       al = '0;
        1:       al = 32'd1 << $urandom_range(0, 31);
        default: al = 32'd1 << $urandom_range(0, 6);
      endcase
      return plain(CMD_ALLOC, sz, al, $urandom);
    end else if (pick < 80 && blk_hdr.size() != 0) begin
      return plain(CMD_FREE, $urandom, $urandom,
                   blk_hdr[$urandom_range(0, blk_hdr.size() - 1)] + HEADER_BYTES);
    end else if (pick < 88) begin
      // bad request: zero size or a non power-of-two alignment
      if ($urandom_range(0, 1) == 0) return plain(CMD_ALLOC, '0, $urandom, $urandom);
      return plain(CMD_ALLOC, $urandom_range(1, 64), $urandom | 32'h3, $urandom);
    end else if (pick < 94) begin
      // huge sizes, mostly running off the top of the address space
      return plain(CMD_ALLOC, $urandom, 32'd1 << $urandom_range(0, 31), $urandom);
    end
    return plain(CMD_FREE, $urandom, $urandom, $urandom);
  endfunction

  // directed table
  stim_row_t directed[] = '{
    // after reset, base 0: first block goes right after the sentinel
    '{CMD_ALLOC, 32'd16, 32'd0, 32'd0, 1'b1, 32'd24, ST_OK},
    '{CMD_ALLOC, 32'd0, 32'd4, 32'd0, 1'b1, 32'd0, ST_BAD},
    '{CMD_ALLOC, 32'd8, 32'd3, 32'd0, 1'b1, 32'd0, ST_BAD},
    '{CMD_ALLOC, 32'd8, 32'hFFFF_FFFF, 32'd0, 1'b1, 32'd0, ST_BAD},
    '{CMD_FREE, 32'd0, 32'd0, 32'd999, 1'b1, 32'd0, ST_MISSING},
    '{CMD_FREE, 32'd0, 32'd0, 32'd12, 1'b1, 32'd0, ST_MISSING},
    '{CMD_ALLOC, 32'hFFFF_FFFF, 32'd1, 32'd0, 1'b1, 32'd0, ST_OVERFLOW},
    '{CMD_ALLOC, 32'd1, 32'h8000_0000, 32'd0, 1'b1, 32'h8000_0000, ST_OK},
    '{CMD_ALLOC, 32'h8000_0000, 32'h8000_0000, 32'd0, 1'b1, 32'd0, ST_OVERFLOW},
    '{CMD_ALLOC, 32'd32, 32'd64, 32'd0, 1'b0, 32'd0, ST_OK},
    '{CMD_ALLOC, 32'd4, 32'd1, 32'd0, 1'b0, 32'd0, ST_OK},
    '{CMD_FREE, 32'd0, 32'd0, 32'd24, 1'b1, 32'd0, ST_OK},
    '{CMD_FREE, 32'd0, 32'd0, 32'd24, 1'b1, 32'd0, ST_MISSING},
    // the hole left at the front is reused first
    '{CMD_ALLOC, 32'd8, 32'd0, 32'd0, 1'b1, 32'd24, ST_OK},
    '{CMD_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 32'd0, ST_OK},
    '{CMD_ALLOC, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b1, 32'd0, ST_OVERFLOW},
    '{CMD_ALLOC, 32'h7FFF_FFFF, 32'd16, 32'd0, 1'b0, 32'd0, ST_OK},
    '{CMD_FREE, 32'd0, 32'd0, 32'd0, 1'b1, 32'd0, ST_MISSING}
  };

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (owed_addr.size() == 0) begin
        $display("%0t: unexpected result item: expected none, actual %h/%0d",
                 $time, out_bus.data_address, out_bus.status);
        failed = 1'b1;
      end else begin
        if (out_bus.data_address !== owed_addr[0]) begin
          $display("%0t: data_address mismatch: expected %h, actual %h",
                   $time, owed_addr[0], out_bus.data_address);
          failed = 1'b1;
        end
        if (out_bus.status !== owed_status[0]) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, owed_status[0], out_bus.status);
          failed = 1'b1;
        end
        void'(owed_addr.pop_front());
        void'(owed_status.pop_front());
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      out_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (!calm) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  // watchdog: cycles with nothing accepted on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
        || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("first_fit_aligned_heap_allocator_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // main sequence
  initial begin
    bit [31:0] bases[5];
    int left;
    failed       = 1'b0;
    calm         = 1'b0;
    quiet_cycles = 0;
    heap_base_m  = '0;
    rst_n        = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.command = CMD_ALLOC;
    in_bus.request_size = '0;
    in_bus.alignment = '0;
    in_bus.free_address = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_item(directed[i]);
    in_bus.valid <= 1'b0;
    wait_drained();

    // fill the table past its limit, then empty it again
    write_heap_base(32'h0000_0100);
    for (int i = 0; i < MAX_BLOCKS + 4; i++) send_item(plain(CMD_ALLOC, 32'd8, 32'd0, '0));
    while (blk_hdr.size() != 0)
      send_item(plain(CMD_FREE, '0, '0,
                      blk_hdr[$urandom_range(0, blk_hdr.size() - 1)] + HEADER_BYTES));
    in_bus.valid <= 1'b0;
    wait_drained();

    // random phases over several heap bases, the extremes among them
    bases = '{32'h0, 32'hFFFF_FFFF, $urandom, 32'hFFFF_F000, 32'h0000_1000};
    left  = 5 * 100;
    foreach (bases[p]) begin
      write_heap_base(bases[p]);
      for (int i = 0; i < 100; i++) begin
        left--;
        if (left < CALM_TAIL) calm = 1'b1;
        send_item(random_item());
      end
      in_bus.valid <= 1'b0;
      if (p != 4) wait_drained();
    end

    while (owed_addr.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (!failed && owed_addr.size() == 0) begin
      $display("first_fit_aligned_heap_allocator_unit test passed");
    end else begin
      $display("first_fit_aligned_heap_allocator_unit test failed");
    end
    $finish;
  end

endmodule
